FILE: sv/bigram_lattice_viterbi_unit_macros.svh
// Assertion helpers for the RTL.
`ifndef BIGRAM_LATTICE_VITERBI_UNIT_MACROS_SVH
`define BIGRAM_LATTICE_VITERBI_UNIT_MACROS_SVH

// Checked while out of reset.
`define BLV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BLV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/blv_pkg.sv
package blv_pkg;

    localparam int C_MAX_LEN  = 32;
    localparam int C_MAX_CAND = 16;
    localparam int C_QDEPTH   = 2;

    localparam logic [1:0] OP_CAND = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_FIN  = 2'd2;

    typedef enum logic [1:0] {
        K_CAND,
        K_EDGE,
        K_FIN
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_WRITE,
        S_SCAN,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_kind        kind;
        logic [4:0]   position;
        logic [3:0]   node_index;
        logic [3:0]   from_index;
        logic [15:0]  cand_word;
        logic [23:0]  trans_count;
    } t_item;

endpackage

FILE: sv/blv_in_if.sv
interface blv_in_if;
    logic         valid;
    logic         ready;
    logic [1:0]   operation;
    logic [4:0]   position;
    logic [3:0]   node_index;
    logic [3:0]   from_index;
    logic [15:0]  cand_word;
    logic [23:0]  trans_count;

    modport source (output valid, operation, position, node_index, from_index, cand_word,
                    trans_count, input ready);
    modport sink (input valid, operation, position, node_index, from_index, cand_word,
                  trans_count, output ready);
endinterface

FILE: sv/blv_out_if.sv
interface blv_out_if;
    logic         valid;
    logic         ready;
    logic [4:0]   out_position;
    logic [15:0]  out_word;
    logic [31:0]  best_score;
    logic         empty_flag;
    logic         last_result;

    modport source (output valid, out_position, out_word, best_score, empty_flag,
                    last_result, input ready);
    modport sink (input valid, out_position, out_word, best_score, empty_flag,
                  last_result, output ready);
endinterface

FILE: sv/blv_front.sv
module blv_front #(
    parameter int P_QDEPTH = blv_pkg::C_QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    blv_in_if.sink         i_in,
    output blv_pkg::t_item o_item,
    output logic           o_valid,
    input  logic           i_pop
);
    import blv_pkg::*;

    localparam int AW = (P_QDEPTH > 1) ? $clog2(P_QDEPTH) : 1;
    localparam int CW = $clog2(P_QDEPTH + 1);

    t_item           r_mem [P_QDEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    t_item           c_item;
    logic            c_push;

    assign i_in.ready = (r_cnt != CW'(P_QDEPTH));

    // op 3 is taken and dropped
    always_comb begin
        c_item.position    = i_in.position;
        c_item.node_index  = i_in.node_index;
        c_item.from_index  = i_in.from_index;
        c_item.cand_word   = i_in.cand_word;
        c_item.trans_count = i_in.trans_count;
        c_push = i_in.valid && i_in.ready;
        unique case (i_in.operation)
            OP_CAND: c_item.kind = K_CAND;
            OP_EDGE: c_item.kind = K_EDGE;
            OP_FIN:  c_item.kind = K_FIN;
            default: begin
                c_item.kind = K_FIN;
                c_push      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_mem[r_wr] <= c_item;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (c_push) begin
                r_wr <= (r_wr == AW'(P_QDEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(P_QDEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(c_push) - CW'(i_pop);
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

endmodule

FILE: sv/blv_back.sv
`include "bigram_lattice_viterbi_unit_macros.svh"

module blv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  blv_pkg::t_item i_item,
    input  logic           i_valid,
    output logic           o_pop,
    blv_out_if.source      o_out
);
    import blv_pkg::*;

    t_state        r_state, n_state;
    t_item         r_it;
    logic [5:0]    r_col_cnt;
    logic [4:0]    r_cur_size, r_prev_size;
    logic [31:0]   r_cur  [C_MAX_CAND];
    logic [31:0]   r_prev [C_MAX_CAND];
    logic [4:0]    r_wcol;
    logic [3:0]    r_sw;
    logic [4:0]    r_idx;
    logic [3:0]    r_best, r_cand;
    logic [31:0]   r_bestv;
    logic          r_empty;

    logic [15:0]   r_wmem [C_MAX_LEN*C_MAX_CAND];
    logic [3:0]    r_bmem [C_MAX_LEN*C_MAX_CAND];
    logic [15:0]   r_word_q;
    logic [3:0]    r_bp_q;

    logic          r_ov, r_oempty, r_olast;
    logic [4:0]    r_opos;
    logic [15:0]   r_oword;
    logic [31:0]   r_oscore;

    logic          c_fresh, c_ext, c_legal, c_grow, c_load, c_better;
    logic [4:0]    c_size;
    logic [32:0]   c_sum;
    logic [31:0]   c_sat;

    // decode of the queued item, and the edge score update
    always_comb begin
        c_fresh = ({1'b0, i_item.position} == r_col_cnt);
        c_ext   = (i_item.position != '0) && ({1'b0, i_item.position} + 6'd1 == r_col_cnt);
        c_legal = 1'b0;
        c_size  = r_cur_size;
        unique case (i_item.kind)
            K_CAND: begin
                c_legal = (r_col_cnt <= 6'd1);
                c_size  = (r_col_cnt == '0) ? '0 : r_cur_size;
            end
            K_EDGE: begin
                c_legal = (r_col_cnt != '0) && (c_fresh || c_ext) &&
                          ({1'b0, i_item.from_index} < (c_fresh ? r_cur_size : r_prev_size));
                c_size  = c_fresh ? '0 : r_cur_size;
            end
            K_FIN:   c_legal = 1'b1;
            default: c_legal = 1'b0;
        endcase
        c_grow   = ({1'b0, i_item.node_index} >= c_size);
        c_sum    = {1'b0, r_prev[r_it.from_index]} + 33'(r_it.trans_count) + 33'd1;
        c_sat    = c_sum[32] ? '1 : c_sum[31:0];
        c_better = (c_sat > r_cur[r_it.node_index]);
        c_load   = !r_ov || o_out.ready;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (c_legal) begin
                        if (i_item.kind == K_FIN) begin
                            n_state = (r_col_cnt == '0) ? S_EMIT : S_SCAN;
                        end else begin
                            n_state = c_grow ? S_SWEEP : S_WRITE;
                        end
                    end
                end
            end
            S_SWEEP: if (r_sw == r_it.node_index) n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            S_SCAN:  if (r_idx >= r_cur_size) n_state = S_READ;
            S_READ:  n_state = S_EMIT;
            S_EMIT: begin
                if (c_load) begin
                    n_state = (r_empty || r_wcol == '0) ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // trace memories: one write port, one registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_SWEEP) begin
            r_wmem[{r_wcol, r_sw}] <= '0;
            r_bmem[{r_wcol, r_sw}] <= '0;
        end else if (r_state == S_WRITE) begin
            r_wmem[{r_wcol, r_it.node_index}] <= r_it.cand_word;
            if (r_it.kind == K_EDGE && c_better) begin
                r_bmem[{r_wcol, r_it.node_index}] <= r_it.from_index;
            end
        end
        if (r_state == S_READ) begin
            r_word_q <= r_wmem[{r_wcol, r_cand}];
            r_bp_q   <= r_bmem[{r_wcol, r_cand}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_cur_size  <= '0;
            r_prev_size <= '0;
            r_empty     <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (r_state == S_EMIT && c_load) r_ov <= 1'b1;
            else if (o_out.ready)            r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && c_legal) begin
                        r_it <= i_item;
                        if (i_item.kind == K_FIN) begin
                            r_empty <= (r_col_cnt == '0);
                            r_best  <= '0;
                            r_bestv <= r_cur[0];
                            r_idx   <= 5'd1;
                            r_wcol  <= 5'(r_col_cnt - 6'd1);
                        end else begin
                            r_sw   <= c_size[3:0];
                            r_wcol <= (i_item.kind == K_CAND) ? '0 : i_item.position;
                            if (i_item.kind == K_CAND && r_col_cnt == '0) r_col_cnt <= 6'd1;
                            if (i_item.kind == K_EDGE && c_fresh) begin
                                r_prev      <= r_cur;
                                r_prev_size <= r_cur_size;
                                r_col_cnt   <= r_col_cnt + 6'd1;
                            end
                            if (c_grow) r_cur_size <= {1'b0, i_item.node_index} + 5'd1;
                            for (int t = 0; t < C_MAX_CAND; t++) begin
                                if (5'(t) >= c_size && 5'(t) <= {1'b0, i_item.node_index}) begin
                                    r_cur[t] <= '0;
                                end
                            end
                        end
                    end
                end
                S_SWEEP: r_sw <= r_sw + 4'd1;
                S_WRITE: begin
                    if (r_it.kind == K_CAND) begin
                        r_cur[r_it.node_index] <= 32'd1;
                    end else if (c_better) begin
                        r_cur[r_it.node_index] <= c_sat;
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_cur_size) begin
                        if (r_cur[r_idx[3:0]] > r_bestv) begin
                            r_bestv <= r_cur[r_idx[3:0]];
                            r_best  <= r_idx[3:0];
                        end
                        r_idx <= r_idx + 5'd1;
                    end else begin
                        r_cand <= r_best;
                    end
                end
                S_READ: ;
                S_EMIT: begin
                    if (c_load) begin
                        r_oempty <= r_empty;
                        r_olast  <= r_empty || (r_wcol == '0);
                        r_opos   <= r_empty ? '0 : r_wcol;
                        r_oword  <= r_empty ? '0 : r_word_q;
                        r_oscore <= r_empty ? '0 : r_bestv;
                        r_empty  <= 1'b0;
                        r_cand   <= r_bp_q;
                        r_wcol   <= r_wcol - 5'd1;
                        if (r_empty || r_wcol == '0) r_col_cnt <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_position = r_opos;
    assign o_out.out_word     = r_oword;
    assign o_out.best_score   = r_oscore;
    assign o_out.empty_flag   = r_oempty;
    assign o_out.last_result  = r_olast;

    `BLV_ASSERT(a_col_cnt_bound, r_col_cnt <= 6'(C_MAX_LEN), "column count past lattice length")
    `BLV_ASSERT(a_size_bound, r_cur_size <= 5'(C_MAX_CAND), "column size past candidate limit")
    `BLV_ASSERT(a_pop_idle, o_pop |-> r_state == S_IDLE && i_valid, "queue popped outside idle")
    `BLV_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> r_state == S_IDLE && !r_ov, "not idle after reset")

endmodule

FILE: sv/bigram_lattice_viterbi_unit.sv
// Best-path search over a character lattice, one result per column on finish, last
// column first. Items enter a short queue and are executed one at a time by the back
// end, which owns the scores and a trace memory with one write port and a registered
// read (word and back-pointer per node). A candidate or edge item ends in a write
// state, preceded by a sweep when it adds node indices to its column (the new trace
// entries are cleared one per cycle through the memory's only write port). A finish
// is followed by a scan of the last column for the best node, then a backtrack over
// the columns, each a registered memory read followed by the output load; a stalled
// output stretches this. An empty finish gives one result with empty_flag set.
// Scores saturate at all ones. No clearing pass is needed after reset.
module bigram_lattice_viterbi_unit #(
    parameter int P_QDEPTH = blv_pkg::C_QDEPTH // front queue depth, items
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blv_in_if.sink     i_in,
    blv_out_if.source  o_out
);
    import blv_pkg::*;

    t_item  w_item;
    logic   w_valid;
    logic   w_pop;

    // front: accept, drop unused op codes, queue
    blv_front #(
        .P_QDEPTH (P_QDEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (w_item),
        .o_valid (w_valid),
        .i_pop   (w_pop)
    );

    // back: lattice update, scan and backtrack
    blv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item),
        .i_valid (w_valid),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

FILE: test/bigram_lattice_viterbi_checker.sv
module bigram_lattice_viterbi_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    blv_in_if    i_in,
    blv_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import blv_pkg::*;

    typedef struct packed {
        logic [4:0]  position;
        logic [15:0] word;
        logic [31:0] score;
        logic        empty;
        logic        last;
    } t_path_char;

    // shadow lattice
    logic [31:0] prev_sc [C_MAX_CAND];
    logic [31:0] cur_sc  [C_MAX_CAND];
    logic [3:0]  back_ptr [C_MAX_LEN*C_MAX_CAND];
    logic [15:0] node_wd  [C_MAX_LEN*C_MAX_CAND];
    int          n_cols;
    int          col_size [C_MAX_LEN];

    t_path_char  path_q[$];
    int          fails;
    int          pend = 0;

    assign o_fail_count = fails;
    assign o_pending    = pend;

    task automatic grow(input int col, input int idx);
        if (idx >= col_size[col]) begin
            for (int t = col_size[col]; t <= idx; t++) begin
                cur_sc[t] = '0;
                back_ptr[col*C_MAX_CAND + t] = '0;
                node_wd[col*C_MAX_CAND + t] = '0;
            end
            col_size[col] = idx + 1;
        end
    endtask

    task automatic walk_lattice(input logic [1:0] op, input int pos, input int node,
                                input int from, input logic [15:0] wd,
                                input logic [23:0] cnt);
        logic [32:0] sum;
        logic [31:0] best_val;
        int          best;
        int          slot;
        int          cand;
        bit          fresh;
        t_path_char  r;
        if (op == OP_CAND) begin
            if (n_cols <= 1) begin
                if (n_cols == 0) begin
                    n_cols = 1;
                    col_size[0] = 0;
                end
                grow(0, node);
                cur_sc[node] = 32'd1;
                node_wd[node] = wd;
            end
        end else if (op == OP_EDGE) begin
            if (n_cols != 0 &&
                ((pos == n_cols && pos < C_MAX_LEN) || (pos >= 1 && pos + 1 == n_cols))) begin
                fresh = (pos == n_cols);
                if (from < col_size[pos-1]) begin
                    if (fresh) begin
                        prev_sc = cur_sc;
                        n_cols++;
                        col_size[pos] = 0;
                    end
                    grow(pos, node);
                    slot = pos*C_MAX_CAND + node;
                    sum = {1'b0, prev_sc[from]} + 33'(cnt) + 33'd1;
                    if (sum[32])
                        sum = {1'b0, 32'hFFFF_FFFF};
                    if (sum[31:0] > cur_sc[node]) begin
                        cur_sc[node] = sum[31:0];
                        back_ptr[slot] = from[3:0];
                    end
                    node_wd[slot] = wd;
                end
            end
        end else if (op == OP_FIN) begin
            if (n_cols == 0) begin
                r = '{position: '0, word: '0, score: '0, empty: 1'b1, last: 1'b1};
                path_q.push_back(r);
            end else begin
                best = 0;
                best_val = cur_sc[0];
                for (int i = 1; i < col_size[n_cols-1]; i++)
                    if (cur_sc[i] > best_val) begin
                        best_val = cur_sc[i];
                        best = i;
                    end
                cand = best;
                for (int col = n_cols - 1; col >= 0; col--) begin
                    slot = col*C_MAX_CAND + cand;
                    r = '{position: col[4:0], word: node_wd[slot], score: best_val,
                          empty: 1'b0, last: (col == 0)};
                    path_q.push_back(r);
                    cand = back_ptr[slot];
                end
                n_cols = 0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_path_char exp_r;
        if (!i_rst_n) begin
            n_cols = 0;
            foreach (col_size[k]) col_size[k] = 0;
            path_q.delete();
            fails = 0;
        end else begin
            // results first: a result never stems from the beat taken at the same edge
            if (i_out.valid && i_out.ready) begin
                if (path_q.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d word=%h score=%h empty=%b last=%b",
                             $time, i_out.out_position, i_out.out_word, i_out.best_score,
                             i_out.empty_flag, i_out.last_result);
                    fails++;
                end else begin
                    exp_r = path_q.pop_front();
                    if (i_out.out_position !== exp_r.position) begin
                        $display("%0t: out_position exp %0d got %0d", $time,
                                 exp_r.position, i_out.out_position);
                        fails++;
                    end
                    if (i_out.out_word !== exp_r.word) begin
                        $display("%0t: out_word exp %h got %h", $time,
                                 exp_r.word, i_out.out_word);
                        fails++;
                    end
                    if (i_out.best_score !== exp_r.score) begin
                        $display("%0t: best_score exp %h got %h", $time,
                                 exp_r.score, i_out.best_score);
                        fails++;
                    end
                    if (i_out.empty_flag !== exp_r.empty) begin
                        $display("%0t: empty_flag exp %b got %b", $time,
                                 exp_r.empty, i_out.empty_flag);
                        fails++;
                    end
                    if (i_out.last_result !== exp_r.last) begin
                        $display("%0t: last_result exp %b got %b", $time,
                                 exp_r.last, i_out.last_result);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                walk_lattice(i_in.operation, int'(i_in.position), int'(i_in.node_index),
                             int'(i_in.from_index), i_in.cand_word, i_in.trans_count);
        end
        pend = path_q.size();
    end
endmodule

FILE: test/bigram_lattice_viterbi_unit_tb.sv
module bigram_lattice_viterbi_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blv_pkg::*;

    // op code 3 has no meaning in the block; it must be dropped silently
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int         ITEM_TARGET = 420;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         HOLD_AT     = 150;   // beat count that triggers the long stall
    localparam int         HOLD_LEN    = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blv_in_if  in_ch();
    blv_out_if out_ch();

    int fail_count;
    int pending;
    int beats_sent = 0;
    int cycles = 0;
    int burst_left = 0;

    always #2 i_clk = ~i_clk;

    bigram_lattice_viterbi_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bigram_lattice_viterbi_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall pattern drawn at random from three modes (always ready, half, mostly
    // stalled), plus one long hold-off once the sender is well into the run so the
    // front queue fills and the input side backs up.
    int  hold_left = 0;
    bit  held = 1'b0;
    int  rx_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!held && beats_sent >= HOLD_AT) begin
            held <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else begin
            if (cycles % 64 == 0)
                rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 1) == 1);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // One input beat; valid stays up across a burst, drops for a random gap after it.
    task automatic send_beat(input logic [1:0] op, input int pos, input int node,
                             input int from, input logic [15:0] wd,
                             input logic [23:0] cnt);
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.position    <= pos[4:0];
        in_ch.node_index  <= node[3:0];
        in_ch.from_index  <= from[3:0];
        in_ch.cand_word   <= wd;
        in_ch.trans_count <= cnt;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        beats_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [23:0] rand_count();
        case ($urandom_range(0, 5))
            0: rand_count = '0;
            1: rand_count = 24'hFF_FFFF;
            default: rand_count = 24'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    // Well-formed lattice with random content, then finish.
    task automatic run_lattice(input int n_cols, input int max_sz);
        int sz;
        int prev_sz;
        sz = $urandom_range(1, max_sz);
        for (int n = 0; n < sz; n++)
            if (n == sz - 1 || $urandom_range(0, 7) != 0)
                send_beat(OP_CAND, $urandom_range(0, 31), n, $urandom_range(0, 15),
                          16'($urandom_range(0, 16'hFFFF)), rand_count());
        for (int c = 1; c < n_cols; c++) begin
            prev_sz = sz;
            sz = $urandom_range(1, max_sz);
            for (int n = 0; n < sz; n++)
                repeat ($urandom_range(1, 3))
                    send_beat(OP_EDGE, c, n, $urandom_range(0, prev_sz - 1),
                              16'($urandom_range(0, 16'hFFFF)), rand_count());
            if ($urandom_range(0, 9) == 0)   // stray beat inside a lattice
                send_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          16'($urandom_range(0, 16'hFFFF)), rand_count());
        end
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);
    endtask

    initial begin
        // Known values on every input from time zero.
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_CAND;
        in_ch.position    <= '0;
        in_ch.node_index  <= '0;
        in_ch.from_index  <= '0;
        in_ch.cand_word   <= '0;
        in_ch.trans_count <= '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);              // empty lattice
        send_beat(OP_CAND, 31, 0, 15, 16'h0000, 24'hFF_FFFF);
        send_beat(OP_CAND, 0, 15, 0, 16'hFFFF, 24'h0);         // skips indices 1..14
        send_beat(OP_CAND, 0, 0, 0, 16'hA5A5, 24'h0);          // repeated index
        send_beat(OP_EDGE, 1, 3, 15, 16'h1111, 24'h0);         // from in range (size 16)
        send_beat(OP_EDGE, 1, 3, 0, 16'h2222, 24'hFF_FFFF);    // max count wins
        send_beat(OP_EDGE, 1, 3, 15, 16'h3333, 24'h0);         // lower, loses
        send_beat(OP_CAND, 0, 1, 0, 16'h4444, 24'h0);          // ignored: col 1 open
        send_beat(OP_EDGE, 5, 0, 0, 16'h5555, 24'h0);          // ignored: wrong column
        send_beat(OP_EDGE, 2, 0, 4, 16'h6666, 24'h0);          // ignored: from past size
        send_beat(OP_EDGE, 2, 15, 3, 16'hFFFF, 24'hFF_FFFF);
        send_beat(OP_EDGE, 2, 7, 3, 16'h7777, 24'hFF_FFFF);    // tie, first max stays
        send_beat(OP_SPARE, 31, 15, 15, 16'hFFFF, 24'hFF_FFFF);
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);
        send_beat(OP_EDGE, 1, 0, 0, 16'h8888, 24'h1);          // ignored: no first column
        send_beat(OP_CAND, 0, 2, 0, 16'h9999, 24'h0);          // single-column lattice
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);              // empty again

        // --- random ---
        while (beats_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: run_lattice(32, $urandom_range(1, 2));      // full-length lattice
                1: send_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, 15),
                             16'($urandom_range(0, 16'hFFFF)), rand_count());
                2: run_lattice($urandom_range(1, 4), 16);
                default: run_lattice($urandom_range(1, 6), $urandom_range(1, 4));
            endcase
        end
        send_beat(OP_FIN, 0, 0, 0, 16'h0, 24'h0);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
